### hdl/antialiased_line_x_major_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the antialiased line core
// Implication forms on the rising clock edge, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef ANTIALIASED_LINE_X_MAJOR_CORE_ASSERT_SVH
`define ANTIALIASED_LINE_X_MAJOR_CORE_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define ALX_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ALX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/alx_pkg.sv
// ----------------------------------------------------------------------------
// alx_pkg
// Types, sizes and helper functions of the antialiased line core.
// ----------------------------------------------------------------------------
`default_nettype none

package alx_pkg;

  localparam int SCREEN_WIDTH   = 1024;
  localparam int SCREEN_HEIGHT  = 1024;
  localparam int GRAD_FRAC_BITS = 16;

  localparam int COORD_W = 16;
  localparam int PIX_W   = 13;
  localparam int COLOR_W = 24;
  localparam int SHADE_W = 8;
  localparam int ROW_W   = 15;
  localparam int ACC_W   = GRAD_FRAC_BITS + ROW_W;
  localparam int QUOT_W  = GRAD_FRAC_BITS + 1;
  localparam int GRAD_W  = GRAD_FRAC_BITS + 2;
  localparam int CNT_W   = $clog2(GRAD_FRAC_BITS);

  localparam logic [QUOT_W-1:0]  GRAD_ONE    = QUOT_W'(1) << GRAD_FRAC_BITS;
  localparam logic [COLOR_W-1:0] COLOR_WHITE = 24'hFFFFFF;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_PAIR  = 2'd1,
    KIND_END   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_LOAD
  } state_t;

  // Q12.4 to integer, halves away from zero.
  function automatic logic signed [PIX_W-1:0] round_q4(input logic signed [COORD_W-1:0] v);
    logic signed [COORD_W:0] ve;
    logic [COORD_W:0]        mag;
    logic [COORD_W+1:0]      sum;
    logic [PIX_W-1:0]        q;
    ve  = {v[COORD_W-1], v};
    mag = ve[COORD_W] ? (COORD_W+1)'(-ve) : (COORD_W+1)'(ve);
    sum = (COORD_W+2)'(mag) + (COORD_W+2)'(8);
    q   = sum[PIX_W+3:4];
    return v[COORD_W-1] ? PIX_W'(-q) : q;
  endfunction

  // floor(255 * part / 2^F)
  function automatic logic [SHADE_W-1:0] shade(input logic [QUOT_W-1:0] part);
    logic [QUOT_W+SHADE_W-1:0] prod;
    prod = {part, 8'b0} - (QUOT_W+SHADE_W)'(part);
    return prod[GRAD_FRAC_BITS+SHADE_W-1:GRAD_FRAC_BITS];
  endfunction

  function automatic logic [COLOR_W-1:0] gray(input logic [SHADE_W-1:0] s);
    return {s, s, s};
  endfunction

endpackage

`default_nettype wire

### hdl/antialiased_line_x_major_core.sv
// ----------------------------------------------------------------------------
// antialiased_line_x_major_core
// Wu-style antialiased rasterizer for x-major lines.
// ----------------------------------------------------------------------------
// A start transfer (func 0) is taken and its rounded start pixel is in the
// output register on the next cycle. The gradient rise/run is then formed by
// a restoring divider that yields one quotient bit per cycle, so in_ready
// stays low through the divide and gradient load states; when rise is zero
// or not below run the divide is skipped and only the load state holds it
// low. Each step transfer (func 1) produces a column pair or the end pixel
// in the output register, so steps run one per clock while results are taken;
// the single output register allows a new transfer in the cycle the held
// result leaves. A step while no line is active is taken and yields nothing.
// ----------------------------------------------------------------------------
`default_nettype none

module antialiased_line_x_major_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 func,
  input  logic signed [alx_pkg::COORD_W-1:0]   start_x,
  input  logic signed [alx_pkg::COORD_W-1:0]   start_y,
  input  logic signed [alx_pkg::COORD_W-1:0]   end_x,
  input  logic signed [alx_pkg::COORD_W-1:0]   end_y,
  input  logic        [alx_pkg::COORD_W-1:0]   run_x,
  input  logic        [alx_pkg::COORD_W-1:0]   rise_y,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output alx_pkg::kind_t                       kind,
  output logic signed [alx_pkg::PIX_W-1:0]     pixel_x,
  output logic signed [alx_pkg::PIX_W-1:0]     upper_y,
  output logic        [alx_pkg::COLOR_W-1:0]   upper_color,
  output logic                                 upper_valid,
  output logic signed [alx_pkg::PIX_W-1:0]     lower_y,
  output logic        [alx_pkg::COLOR_W-1:0]   lower_color,
  output logic                                 lower_valid,
  output logic                                 done_res
);
  import alx_pkg::*;

  state_t                    state, state_next;
  logic                      busy;
  logic signed [PIX_W-1:0]   column;
  logic signed [COORD_W-1:0] stop_x, stop_y, line_y;
  logic                      falling;
  logic signed [ACC_W-1:0]   row_accumulator;
  logic signed [GRAD_W-1:0]  gradient;
  logic [COORD_W-1:0]        divisor, remainder;
  logic [QUOT_W-1:0]         quotient;
  logic [CNT_W-1:0]          count;

  logic                      start_fire, step_fire, result_fire;
  logic                      swap;
  logic signed [COORD_W-1:0] first_x, first_y, last_x, last_y;
  logic signed [PIX_W-1:0]   first_col, first_row, stop_col, stop_row;
  logic                      more;
  logic [GRAD_FRAC_BITS-1:0] frac;
  logic signed [ROW_W-1:0]   row_floor, row, row_below;
  logic [SHADE_W-1:0]        up_shade, lo_shade;
  logic                      col_on, row_on, below_on;
  logic [COORD_W:0]          rem_shift, rem_diff;
  logic                      rem_ge;
  logic signed [GRAD_W-1:0]  grad_mag, grad_val;
  logic signed [ACC_W-1:0]   acc_start;

  assign start_fire  = in_valid && in_ready && (func == FUNC_START);
  assign step_fire   = in_valid && in_ready && (func == FUNC_STEP);
  assign result_fire = start_fire || (step_fire && busy);

  assign swap      = end_x < start_x;
  assign first_x   = swap ? end_x   : start_x;
  assign first_y   = swap ? end_y   : start_y;
  assign last_x    = swap ? start_x : end_x;
  assign last_y    = swap ? start_y : end_y;
  assign first_col = round_q4(first_x);
  assign first_row = round_q4(first_y);
  assign stop_col  = round_q4(stop_x);
  assign stop_row  = round_q4(stop_y);

  assign more      = $signed({column, 4'b0}) < $signed({stop_x[COORD_W-1], stop_x});
  assign frac      = row_accumulator[GRAD_FRAC_BITS-1:0];
  assign row_floor = row_accumulator[ACC_W-1:GRAD_FRAC_BITS];
  assign row       = (row_accumulator[ACC_W-1] && (|frac)) ? row_floor + ROW_W'(1) : row_floor;
  assign row_below = row + ROW_W'(1);
  assign up_shade  = shade(GRAD_ONE - {1'b0, frac});
  assign lo_shade  = shade({1'b0, frac});
  assign col_on    = !column[PIX_W-1] &&
                     ({1'b0, column[PIX_W-2:0]} < PIX_W'(SCREEN_WIDTH));
  assign row_on    = !row[ROW_W-1] && (row < ROW_W'(SCREEN_HEIGHT));
  assign below_on  = !row_below[ROW_W-1] && (row_below < ROW_W'(SCREEN_HEIGHT));

  assign rem_shift = {remainder, 1'b0};
  assign rem_ge    = rem_shift >= {1'b0, divisor};
  assign rem_diff  = rem_shift - {1'b0, divisor};

  assign grad_mag  = GRAD_W'({1'b0, quotient});
  assign grad_val  = falling ? -grad_mag : grad_mag;
  assign acc_start = (ACC_W'(line_y) <<< (GRAD_FRAC_BITS - 4)) + ACC_W'(grad_val);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = !out_valid || out_ready;
        if (in_valid && in_ready && (func == FUNC_START)) begin
          state_next = ((rise_y == '0) || (rise_y >= run_x)) ? ST_LOAD : ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (count == '0) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // line state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy            <= 1'b0;
      column          <= '0;
      stop_x          <= '0;
      stop_y          <= '0;
      row_accumulator <= '0;
      gradient        <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (result_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (start_fire) begin
        busy   <= 1'b1;
        stop_x <= last_x;
        stop_y <= last_y;
        column <= first_col + PIX_W'(1);
      end else if (step_fire && busy) begin
        if (more) begin
          row_accumulator <= row_accumulator + ACC_W'(gradient);
          column          <= column + PIX_W'(1);
        end else begin
          busy <= 1'b0;
        end
      end
      if (state == ST_LOAD) begin
        gradient        <= grad_val;
        row_accumulator <= acc_start;
      end
    end
  end

  // divider
  always_ff @(posedge clk) begin
    if (start_fire) begin
      line_y    <= first_y;
      falling   <= last_y < first_y;
      divisor   <= run_x;
      remainder <= rise_y;
      count     <= CNT_W'(GRAD_FRAC_BITS - 1);
      if (rise_y == '0) begin
        quotient <= '0;
      end else if (rise_y >= run_x) begin
        quotient <= GRAD_ONE;
      end else begin
        quotient <= '0;
      end
    end else if (state == ST_DIVIDE) begin
      remainder <= rem_ge ? rem_diff[COORD_W-1:0] : rem_shift[COORD_W-1:0];
      quotient  <= {quotient[QUOT_W-2:0], rem_ge};
      count     <= count - CNT_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (start_fire) begin
      kind        <= KIND_START;
      pixel_x     <= first_col;
      upper_y     <= first_row;
      upper_color <= COLOR_WHITE;
      upper_valid <= 1'b1;
      lower_y     <= '0;
      lower_color <= '0;
      lower_valid <= 1'b0;
      done_res    <= 1'b0;
    end else if (step_fire && busy) begin
      if (more) begin
        kind        <= KIND_PAIR;
        pixel_x     <= column;
        upper_y     <= row[PIX_W-1:0];
        upper_color <= gray(up_shade);
        upper_valid <= col_on && row_on;
        lower_y     <= row_below[PIX_W-1:0];
        lower_color <= gray(lo_shade);
        lower_valid <= col_on && below_on;
        done_res    <= 1'b0;
      end else begin
        kind        <= KIND_END;
        pixel_x     <= stop_col;
        upper_y     <= stop_row;
        upper_color <= COLOR_WHITE;
        upper_valid <= 1'b1;
        lower_y     <= '0;
        lower_color <= '0;
        lower_valid <= 1'b0;
        done_res    <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/alx_checker.sv
// ----------------------------------------------------------------------------
// alx_checker
// Port-level checks of the antialiased line core, bound to the core module.
// ----------------------------------------------------------------------------
`default_nettype none

`include "antialiased_line_x_major_core_assert.svh"

module alx_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 func,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input alx_pkg::kind_t                       kind,
  input logic signed [alx_pkg::PIX_W-1:0]     pixel_x,
  input logic signed [alx_pkg::PIX_W-1:0]     upper_y,
  input logic        [alx_pkg::COLOR_W-1:0]   upper_color,
  input logic                                 upper_valid,
  input logic signed [alx_pkg::PIX_W-1:0]     lower_y,
  input logic        [alx_pkg::COLOR_W-1:0]   lower_color,
  input logic                                 lower_valid,
  input logic                                 done_res
);
  import alx_pkg::*;

  logic [SHADE_W:0] shade_sum;

  assign shade_sum = {1'b0, upper_color[SHADE_W-1:0]} + {1'b0, lower_color[SHADE_W-1:0]};

  `ALX_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(kind) && $stable(pixel_x) && $stable(upper_y) && $stable(done_res),
    "result changed while stalled")

  `ALX_ASSERT_SAME(a_done_on_end, out_valid, done_res == (kind == KIND_END),
    "done flag does not match end result")

  `ALX_ASSERT_SAME(a_endpoint_form, out_valid && (kind != KIND_PAIR),
    upper_valid && !lower_valid && (upper_color == COLOR_WHITE) && (lower_color == '0),
    "endpoint result malformed")

  `ALX_ASSERT_SAME(a_pair_shades, out_valid && (kind == KIND_PAIR),
    (lower_y == upper_y + PIX_W'(1)) && ((shade_sum == 9'd255) || (shade_sum == 9'd254)),
    "pair rows or shades inconsistent")

  `ALX_ASSERT_NEXT(a_start_blocks, in_valid && in_ready && (func == FUNC_START), !in_ready,
    "input taken while gradient in progress")

endmodule

bind antialiased_line_x_major_core alx_checker u_alx_checker (.*);

`default_nettype wire

### verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the x-major antialiased line core. Lines are driven as a
// start transfer followed by column steps, with random gaps on the input
// and random stalls on the output. A scoreboard class tracks the line state
// of its own, predicts every start pixel, column pair and end pixel, and
// compares each result field by field in order.
// ----------------------------------------------------------------------------
module tb;
  import alx_pkg::*;

  typedef struct {
    logic               func;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic signed [15:0] ex;
    logic signed [15:0] ey;
    logic [15:0]        run;
    logic [15:0]        rise;
  } line_cmd_t;

  typedef struct {
    kind_t       kind;
    logic [12:0] px;
    logic [12:0] uy;
    logic [23:0] uc;
    logic        uv;
    logic [12:0] ly;
    logic [23:0] lc;
    logic        lv;
    logic        dn;
  } pixel_res_t;

  class raster_checker;
    pixel_res_t pixels_due[$];
    int         col;
    int         stop_x;
    int         stop_y;
    longint     acc;
    longint     grad;
    bit         busy;
    int         n_lines;
    int         n_pairs;
    int         n_ends;
    int         n_idle;
    int         n_errors;

    function int nearest_pixel(int v);
      if (v >= 0) return (v + 8) / 16;
      return -((8 - v) / 16);
    endfunction

    function bit on_screen(longint x, longint y);
      return x >= 0 && x < SCREEN_WIDTH && y >= 0 && y < SCREEN_HEIGHT;
    endfunction

    function logic [23:0] gray24(longint s);
      return 24'(s * 24'h010101);
    endfunction

    function pixel_res_t make_res(kind_t k, longint px, longint uy, logic [23:0] uc,
                                  bit uv, longint ly, logic [23:0] lc, bit lv, bit dn);
      pixel_res_t r;
      r.kind = k;
      r.px   = 13'(px);
      r.uy   = 13'(uy);
      r.uc   = uc;
      r.uv   = uv;
      r.ly   = 13'(ly);
      r.lc   = lc;
      r.lv   = lv;
      r.dn   = dn;
      return r;
    endfunction

    function void accept_cmd(line_cmd_t c);
      int     ax, ay, bx, by, t;
      longint one, mag, row, frac, up_s, lo_s;
      one = longint'(1) << GRAD_FRAC_BITS;
      if (c.func == FUNC_START) begin
        ax = c.sx;
        ay = c.sy;
        bx = c.ex;
        by = c.ey;
        if (bx < ax) begin
          t = ax; ax = bx; bx = t;
          t = ay; ay = by; by = t;
        end
        if (c.rise == 0) mag = 0;
        else if (c.rise >= c.run) mag = one;
        else mag = (longint'(c.rise) << GRAD_FRAC_BITS) / longint'(c.run);
        grad   = (by < ay) ? -mag : mag;
        acc    = longint'(ay) * (longint'(1) << (GRAD_FRAC_BITS - 4)) + grad;
        stop_x = bx;
        stop_y = by;
        col    = nearest_pixel(ax) + 1;
        busy   = 1'b1;
        n_lines++;
        pixels_due.push_back(make_res(KIND_START, nearest_pixel(ax), nearest_pixel(ay),
                                      COLOR_WHITE, 1'b1, 0, 24'h0, 1'b0, 1'b0));
      end else if (!busy) begin
        n_idle++;
      end else if (longint'(col) * 16 < longint'(stop_x)) begin
        row  = (acc >= 0) ? (acc >>> GRAD_FRAC_BITS) : -((-acc) >>> GRAD_FRAC_BITS);
        frac = acc & (one - 1);
        up_s = (255 * (one - frac)) >>> GRAD_FRAC_BITS;
        lo_s = (255 * frac) >>> GRAD_FRAC_BITS;
        n_pairs++;
        pixels_due.push_back(make_res(KIND_PAIR, col, row, gray24(up_s), on_screen(col, row),
                                      row + 1, gray24(lo_s), on_screen(col, row + 1), 1'b0));
        acc = acc + grad;
        col = col + 1;
      end else begin
        busy = 1'b0;
        n_ends++;
        pixels_due.push_back(make_res(KIND_END, nearest_pixel(stop_x), nearest_pixel(stop_y),
                                      COLOR_WHITE, 1'b1, 0, 24'h0, 1'b0, 1'b1));
      end
    endfunction

    function void field_eq(string name, logic [23:0] want, logic [23:0] seen);
      if (want !== seen) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, seen);
        n_errors++;
      end
    endfunction

    function void match_pixel(pixel_res_t got);
      pixel_res_t w;
      if (pixels_due.size() == 0) begin
        $error("result kind %0d at x 0x%0h with nothing pending", got.kind, got.px);
        n_errors++;
        return;
      end
      w = pixels_due.pop_front();
      field_eq("kind", w.kind, got.kind);
      field_eq("pixel_x", w.px, got.px);
      field_eq("upper_y", w.uy, got.uy);
      field_eq("upper_color", w.uc, got.uc);
      field_eq("upper_valid", w.uv, got.uv);
      field_eq("lower_y", w.ly, got.ly);
      field_eq("lower_color", w.lc, got.lc);
      field_eq("lower_valid", w.lv, got.lv);
      field_eq("done_res", w.dn, got.dn);
    endfunction
  endclass

  logic                       clk;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       func = FUNC_START;
  logic signed [COORD_W-1:0]  start_x = '0;
  logic signed [COORD_W-1:0]  start_y = '0;
  logic signed [COORD_W-1:0]  end_x = '0;
  logic signed [COORD_W-1:0]  end_y = '0;
  logic        [COORD_W-1:0]  run_x = '0;
  logic        [COORD_W-1:0]  rise_y = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  kind_t                      kind;
  logic signed [PIX_W-1:0]    pixel_x;
  logic signed [PIX_W-1:0]    upper_y;
  logic        [COLOR_W-1:0]  upper_color;
  logic                       upper_valid;
  logic signed [PIX_W-1:0]    lower_y;
  logic        [COLOR_W-1:0]  lower_color;
  logic                       lower_valid;
  logic                       done_res;

  raster_checker sb = new();
  int            items_sent;
  bit            steady;
  bit            paused;

  antialiased_line_x_major_core uut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL antialiased_line_x_major_core");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(0, 99) >= 35);
    end
  end

  always @(posedge clk) begin
    pixel_res_t got;
    line_cmd_t  c;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got.kind = kind;
        got.px   = pixel_x;
        got.uy   = upper_y;
        got.uc   = upper_color;
        got.uv   = upper_valid;
        got.ly   = lower_y;
        got.lc   = lower_color;
        got.lv   = lower_valid;
        got.dn   = done_res;
        sb.match_pixel(got);
      end
      if (in_valid && in_ready) begin
        c.func = func;
        c.sx   = start_x;
        c.sy   = start_y;
        c.ex   = end_x;
        c.ey   = end_y;
        c.run  = run_x;
        c.rise = rise_y;
        sb.accept_cmd(c);
      end
    end
  end

  function automatic line_cmd_t start_cmd(int x0, int y0, int x1, int y1, int run, int rise);
    line_cmd_t c;
    c.func = FUNC_START;
    c.sx   = 16'(x0);
    c.sy   = 16'(y0);
    c.ex   = 16'(x1);
    c.ey   = 16'(y1);
    c.run  = 16'(run);
    c.rise = 16'(rise);
    return c;
  endfunction

  function automatic line_cmd_t step_cmd();
    line_cmd_t c;
    c.func = FUNC_STEP;
    c.sx   = 16'($urandom);
    c.sy   = 16'($urandom);
    c.ex   = 16'($urandom);
    c.ey   = 16'($urandom);
    c.run  = 16'($urandom);
    c.rise = 16'($urandom);
    return c;
  endfunction

  // Steps needed to finish a line: one per column pair plus the end pixel.
  function automatic int line_steps(int a, int b);
    int lo, hi, c, n;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    n  = 1;
    for (c = sb.nearest_pixel(lo) + 1; c * 16 < hi; c++) n++;
    return n;
  endfunction

  task automatic send(input line_cmd_t c, input bit counts);
    if (!steady && $urandom_range(0, 99) < 35) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= c.func;
    start_x  <= c.sx;
    start_y  <= c.sy;
    end_x    <= c.ex;
    end_y    <= c.ey;
    run_x    <= c.run;
    rise_y   <= c.rise;
    do @(posedge clk); while (!in_ready);
    if (counts) items_sent++;
  endtask

  task automatic draw(int x0, int y0, int x1, int y1, int run, int rise, int steps, int live);
    int i;
    send(start_cmd(x0, y0, x1, y1, run, rise), 1'b1);
    for (i = 0; i < steps; i++) send(step_cmd(), i < live);
  endtask

  // mode 0: complete line, 1: cut short by the next start, 2: extra steps past the end
  task automatic random_line(int maxlen, int mode);
    int dx, dy, x0, y0, full, steps, live;
    dx   = $urandom_range(1, maxlen);
    dy   = $urandom_range(0, dx);
    x0   = int'($urandom_range(0, 16 * 1150)) - 16 * 60;
    y0   = int'($urandom_range(0, 16 * 1150)) - 16 * 60;
    full = line_steps(x0, x0 + dx);
    if (mode == 0) steps = full;
    else if (mode == 1) steps = $urandom_range(0, full - 1);
    else steps = full + $urandom_range(1, 3);
    live = (steps < full) ? steps : full;
    if ($urandom_range(0, 1)) begin
      if ($urandom_range(0, 1)) draw(x0 + dx, y0 - dy, x0, y0, dx, dy, steps, live);
      else draw(x0 + dx, y0 + dy, x0, y0, dx, dy, steps, live);
    end else begin
      if ($urandom_range(0, 1)) draw(x0, y0, x0 + dx, y0 - dy, dx, dy, steps, live);
      else draw(x0, y0, x0 + dx, y0 + dy, dx, dy, steps, live);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pixels_due.size() != 0);
  endtask

  initial begin
    int i, p, n;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send(step_cmd(), 1'b0);
    draw(-32768, 32767, 32767, -32768, 65535, 65535, 2, 2);
    draw(32767, -32768, -32768, 32767, 0, 0, 1, 1);
    draw(160, 80, 208, 128, 0, 5, line_steps(160, 208), line_steps(160, 208));
    draw(100, 0, 100, 0, 16, 0, 1, 1);
    draw(100, 50, 105, 40, 5, 10, 1, 1);
    send(step_cmd(), 1'b0);
    draw(16 * 1021, 16 * 1022, 16 * 1025, 16 * 1024, 64, 32, 4, 4);
    draw(-8, -24, 40, 24, 48, 40, 4, 4);

    while (items_sent < 1950) begin
      steady = (items_sent >= 700 && items_sent < 1000);
      if (!paused && items_sent >= 1300) begin
        paused = 1'b1;
        drain();
      end
      p = $urandom_range(0, 99);
      if (p < 68) begin
        random_line(16 * 24, 0);
      end else if (p < 70) begin
        random_line(16 * 120, 0);
      end else if (p < 81) begin
        send(start_cmd($urandom, $urandom, $urandom, $urandom, $urandom, $urandom), 1'b1);
        n = $urandom_range(0, 4);
        for (i = 0; i < n; i++) send(step_cmd(), 1'b1);
      end else if (p < 91) begin
        random_line(16 * 24, 1);
      end else begin
        random_line(16 * 24, 2);
      end
    end

    drain();
    repeat (24) @(posedge clk);
    $display("Drew %0d lines: %0d column pairs and %0d end pixels checked",
             sb.n_lines, sb.n_pairs, sb.n_ends);
    $display("%0d steps arrived with no line open, %0d mismatches", sb.n_idle, sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("PASS antialiased_line_x_major_core");
    end else begin
      $display("FAIL antialiased_line_x_major_core");
    end
    $finish;
  end

endmodule
